/* rtl/mme_pkg.sv */
package mme_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned DIM_W     = 4;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_START  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  // tag that travels with each multiply-accumulate slot
  typedef struct packed {
    logic valid;
    logic first;
    logic last_k;
    logic last_el;
    logic err;
  } issue_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    err;
    logic                    last;
  } res_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
      return ACC_MAX;
    end
    if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
      return ACC_MIN;
    end
    return s;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(
    input logic [DIM_W-1:0] v,
    input logic [DIM_W-1:0] max_dim
  );
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (v > max_dim) begin
      return max_dim;
    end
    return v;
  endfunction

endpackage

/* rtl/mme_store.sv */
module mme_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic signed [mme_pkg::VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic signed [mme_pkg::VAL_W-1:0] rdata_o
);
  import mme_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        written_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic                    rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= written_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/mme_ctrl.sv */
module mme_ctrl #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned AW      = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  mme_pkg::dims_t        dims_i,
  input  logic                  out_pop_i,
  output logic                  busy_o,
  output mme_pkg::issue_t       issue_o,
  output logic [AW-1:0]         a_addr_o,
  output logic [AW-1:0]         b_addr_o
);
  import mme_pkg::*;

  localparam int unsigned PEND_W = $clog2(OUT_DEPTH + 1);
  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

  seq_state_e        state_q, state_d;
  logic              err_q, err_d;
  logic [DIM_W-1:0]  r_q, r_d, c_q, c_d, k_q, k_d;
  logic [AW:0]       row_base_q, row_base_d;
  logic [AW:0]       a_addr_q, a_addr_d;
  logic [AW:0]       b_addr_q, b_addr_d;
  logic [PEND_W-1:0] pend_q, pend_d;

  logic [DIM_W-1:0]  ar, ac, br, bc;
  logic              credit;
  logic              last_k, last_c, last_r;
  issue_t            issue;

  assign ar = eff_dim(dims_i.a_rows, MaxDim);
  assign ac = eff_dim(dims_i.a_cols, MaxDim);
  assign br = eff_dim(dims_i.b_rows, MaxDim);
  assign bc = eff_dim(dims_i.b_cols, MaxDim);

  assign credit = pend_q < PEND_W'(OUT_DEPTH);
  assign last_k = k_q == ac - DIM_W'(1);
  assign last_c = c_q == bc - DIM_W'(1);
  assign last_r = r_q == ar - DIM_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      err_q      <= 1'b0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      row_base_q <= '0;
      a_addr_q   <= '0;
      b_addr_q   <= '0;
      pend_q     <= '0;
    end else begin
      state_q    <= state_d;
      err_q      <= err_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      row_base_q <= row_base_d;
      a_addr_q   <= a_addr_d;
      b_addr_q   <= b_addr_d;
      pend_q     <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    row_base_d = row_base_q;
    a_addr_d   = a_addr_q;
    b_addr_d   = b_addr_q;
    issue      = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          err_d      = ac != br;
          r_d        = '0;
          c_d        = '0;
          k_d        = '0;
          row_base_d = '0;
          a_addr_d   = '0;
          b_addr_d   = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (err_q) begin
          if (credit) begin
            issue   = '{valid: 1'b1, first: 1'b1, last_k: 1'b1, last_el: 1'b1, err: 1'b1};
            state_d = ST_IDLE;
          end
        end else if (k_q != '0 || credit) begin
          issue = '{valid: 1'b1, first: k_q == '0, last_k: last_k,
                    last_el: last_k && last_c && last_r, err: 1'b0};
          if (last_k) begin
            k_d = '0;
            if (last_c) begin
              c_d        = '0;
              r_d        = r_q + DIM_W'(1);
              row_base_d = row_base_q + (AW+1)'(ac);
              a_addr_d   = row_base_q + (AW+1)'(ac);
              b_addr_d   = '0;
              if (last_r) begin
                state_d = ST_IDLE;
              end
            end else begin
              c_d      = c_q + DIM_W'(1);
              a_addr_d = row_base_q;
              b_addr_d = (AW+1)'(c_q) + (AW+1)'(1);
            end
          end else begin
            k_d      = k_q + DIM_W'(1);
            a_addr_d = a_addr_q + (AW+1)'(1);
            b_addr_d = b_addr_q + (AW+1)'(bc);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // elements launched but not yet delivered; bounds the output queue
  always_comb begin
    pend_d = pend_q;
    if (issue.valid && issue.first) begin
      pend_d = pend_d + PEND_W'(1);
    end
    if (out_pop_i) begin
      pend_d = pend_d - PEND_W'(1);
    end
  end

  assign busy_o   = state_q != ST_IDLE;
  assign issue_o  = issue;
  assign a_addr_o = a_addr_q[AW-1:0];
  assign b_addr_o = b_addr_q[AW-1:0];

endmodule

/* rtl/mme_mac.sv */
module mme_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mme_pkg::issue_t                  issue_i,
  input  logic signed [mme_pkg::VAL_W-1:0] a_data_i,
  input  logic signed [mme_pkg::VAL_W-1:0] b_data_i,
  output logic                             push_o,
  output mme_pkg::res_t                    res_o
);
  import mme_pkg::*;

  issue_t                  tag1_q, tag2_q, tag3_q;
  logic signed [ACC_W-1:0] prod_q, acc_q;
  logic signed [ACC_W-1:0] prod_d, acc_d, shifted;
  logic                    ovf;

  assign prod_d = a_data_i * b_data_i;
  assign acc_d  = tag2_q.first ? prod_q : sat_add(acc_q, prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= issue_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      prod_q <= prod_d;
    end
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign shifted = acc_q >>> FRAC_BITS;
  assign ovf     = !(&shifted[ACC_W-1:VAL_W-1]) && (|shifted[ACC_W-1:VAL_W-1]);

  always_comb begin
    res_o = '0;
    if (tag3_q.err) begin
      res_o.err = 1'b1;
    end else if (ovf) begin
      res_o.value = shifted[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res_o.value = shifted[VAL_W-1:0];
    end
    res_o.last = tag3_q.last_el;
  end

  assign push_o = tag3_q.valid && tag3_q.last_k;

endmodule

/* rtl/mme_ofifo.sv */
module mme_ofifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mme_pkg::res_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output mme_pkg::res_t data_o
);
  import mme_pkg::*;

  localparam int unsigned PW = $clog2(OUT_DEPTH);

  res_t          buf_q [OUT_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_q];

endmodule

/* rtl/matrix_multiply_engine_top.sv */
// Load request: written to the A or B store, no result.
// Start request: products are formed by the single multiply-accumulate unit, which reads
// one entry of each store per product; finished elements wait in the four-entry output queue,
// and a new element is begun only while that queue has room.
// Size mismatch: one error result after the start request, no products.
// Reset: dimension registers to 8, both stores read as zero through per-entry
// written flags, no clearing pass; input is taken from the first cycle.
module matrix_multiply_engine_top #(
  parameter int unsigned MAX_DIM   = mme_pkg::MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = mme_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [mme_pkg::IDX_W-1:0]        elem_index_i,
  input  logic signed [mme_pkg::VAL_W-1:0] elem_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [mme_pkg::VAL_W-1:0] prod_value_o,
  output logic                             size_error_o,
  output logic                             last_result_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mme_pkg::DIM_W-1:0]        cfg_data_i
);
  import mme_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W:0] DepthLim = (IDX_W+1)'(DEPTH);

  dims_t                   dims_q;
  logic                    busy, in_acc, idx_ok, we_a, we_b, start, pop, push;
  issue_t                  issue;
  logic [AW-1:0]           a_addr, b_addr;
  logic signed [VAL_W-1:0] a_data, b_data;
  res_t                    res, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_A_ROWS: dims_q.a_rows <= cfg_data_i;
        CFG_A_COLS: dims_q.a_cols <= cfg_data_i;
        CFG_B_ROWS: dims_q.b_rows <= cfg_data_i;
        CFG_B_COLS: dims_q.b_cols <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_ok     = {1'b0, elem_index_i} < DepthLim;
  assign we_a       = in_acc && idx_ok && action_i == ACT_LOAD_A;
  assign we_b       = in_acc && idx_ok && action_i == ACT_LOAD_B;
  assign start      = in_acc && action_i == ACT_START;

  mme_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk_i, .rst_ni,
    .we_i(we_a), .waddr_i(elem_index_i[AW-1:0]), .wdata_i(elem_value_i),
    .raddr_i(a_addr), .rdata_o(a_data)
  );

  mme_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk_i, .rst_ni,
    .we_i(we_b), .waddr_i(elem_index_i[AW-1:0]), .wdata_i(elem_value_i),
    .raddr_i(b_addr), .rdata_o(b_data)
  );

  mme_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .dims_i(dims_q), .out_pop_i(pop),
    .busy_o(busy), .issue_o(issue), .a_addr_o(a_addr), .b_addr_o(b_addr)
  );

  mme_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i, .rst_ni,
    .issue_i(issue), .a_data_i(a_data), .b_data_i(b_data),
    .push_o(push), .res_o(res)
  );

  mme_ofifo u_ofifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(res), .pop_i(pop),
    .valid_o(out_valid_o), .data_o(head)
  );

  assign pop           = out_valid_o && !out_stall_i;
  assign prod_value_o  = head.value;
  assign size_error_o  = head.err;
  assign last_result_o = head.last;

endmodule

/* rtl/mme_checker.sv */
module mme_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [1:0]                       action_i,
  input logic [mme_pkg::IDX_W-1:0]        elem_index_i,
  input logic signed [mme_pkg::VAL_W-1:0] elem_value_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [mme_pkg::VAL_W-1:0] prod_value_o,
  input logic                             size_error_o,
  input logic                             last_result_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [mme_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [mme_pkg::DIM_W-1:0]        cfg_data_i
);
  import mme_pkg::*;

  // a start request locks out further input for the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ACT_START |=> in_stall_o)
    else $error("input not held off after start request");

  // error result is always alone, zero and final
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> last_result_o && prod_value_o == '0)
    else $error("malformed size error result");

  // handshake outputs always defined
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o, cfg_ready_o}))
    else $error("unknown handshake output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(prod_value_o)
      && $stable(last_result_o))
    else $error("stalled result changed");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (.*);
